>>> sv/phsd_pkg.sv
// Shared types, constants and helpers for the pixel hit stream deframer.
package phsd_pkg;

  localparam logic [7:0]  IDLE_BYTE     = 8'hBC;
  localparam logic [7:0]  MARK_BYTE     = 8'hFF;
  localparam logic [4:0]  MARK_OFFSET   = 5'd4;
  localparam logic [4:0]  FINE_OFF      = 5'd7;
  localparam logic [4:0]  COARSE_FIRST  = 5'd8;
  localparam logic [4:0]  COARSE_LAST   = 5'd13;
  localparam logic [4:0]  DECODE_START  = 5'd16;
  localparam logic [4:0]  TRIG_MIN_OFF  = 5'd19;
  localparam logic [4:0]  OFFSET_CAP    = 5'd31;
  localparam logic [1:0]  HOLD_BYTES    = 2'd3;
  localparam logic [5:0]  MAX_CHANNEL_RESET = 6'd34;
  localparam logic [17:0] COARSE_SCALE  = 18'd1000;
  localparam int          FINE_SHIFT    = 3;
  localparam logic [39:0] RSV_MASK      = 40'h000F000200;
  localparam int          REC_FIFO_DEPTH = 4;
  localparam int          TRIG_W        = 58;

  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_DROP  = 2'd2
  } record_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  // Decoded hit as it is held before release.
  typedef struct packed {
    logic [4:0]  chip_id;
    logic [2:0]  payload_code;
    logic        is_column;
    logic [5:0]  channel;
    logic [7:0]  hit_time;
    logic [11:0] time_over_threshold;
  } hit_t;

  typedef struct packed {
    record_kind_t        record_kind;
    logic [4:0]          chip_id;
    logic [2:0]          payload_code;
    logic                is_column;
    logic [5:0]          channel;
    logic [7:0]          hit_time;
    logic [11:0]         time_over_threshold;
    logic [TRIG_W-1:0]   trigger_time;
    logic                last;
  } out_item_t;

  // Records produced by one accepted byte, written into the output queue.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  rec0;
    out_item_t  rec1;
  } push_t;

  function automatic out_item_t make_record(record_kind_t kind, hit_t hit,
                                            logic [TRIG_W-1:0] trig);
    out_item_t r;
    r.record_kind         = kind;
    r.chip_id             = hit.chip_id;
    r.payload_code        = hit.payload_code;
    r.is_column           = hit.is_column;
    r.channel             = hit.channel;
    r.hit_time            = hit.hit_time;
    r.time_over_threshold = hit.time_over_threshold;
    r.trigger_time        = trig;
    r.last                = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/phsd_parse.sv
// Byte parser: marker search, header capture, word assembly and hit hold.
module phsd_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  phsd_pkg::in_item_t in_item,
  input  logic [5:0]         max_channel,
  output phsd_pkg::push_t    push
);
  import phsd_pkg::*;

  logic [7:0]        rb_r [3];
  logic [7:0]        rb_nxt [3];
  logic [1:0]        rfill_r, rfill_nxt;
  logic              open_r, open_nxt;
  logic [4:0]        off_r, off_nxt;
  logic              stopped_r, stopped_nxt;
  logic              skip_r, skip_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [2:0]        wfill_r, wfill_nxt;
  logic [TRIG_W-1:0] trig_r, trig_nxt;
  hit_t              pend_r, pend_nxt;
  logic [1:0]        age_r, age_nxt;

  logic [7:0]        b;
  logic              eof;
  logic              marker;
  logic [39:0]       full_word;
  logic [5:0]        fch;
  logic [3:0]        tot_hi;
  logic [7:0]        tot_lo;
  hit_t              new_hit;
  logic              hit_ok;
  logic [17:0]       prod;
  logic [TRIG_W-1:0] addend;
  logic              release_hit;
  logic              open_eff;
  hit_t              no_hit;
  out_item_t         close_rec, drop_rec, hit_rec;

  assign b   = in_item.data_byte;
  assign eof = in_item.end_of_file;

  assign marker = (rfill_r == 2'd3) && (rb_r[0] == MARK_BYTE) && (rb_r[1] == MARK_BYTE)
               && (rb_r[2] == MARK_BYTE) && (b == MARK_BYTE);

  // The fifth byte of a word is the current byte; it never goes to storage.
  assign full_word = {b, word_r};
  assign fch       = {<<{full_word[15:10]}};
  assign tot_hi    = {<<{full_word[31:28]}};
  assign tot_lo    = {<<{full_word[39:32]}};
  assign hit_ok    = ((full_word & RSV_MASK) == 40'd0) && (fch <= max_channel);

  always_comb begin
    new_hit.chip_id             = {<<{full_word[4:0]}};
    new_hit.payload_code        = {<<{full_word[7:5]}};
    new_hit.is_column           = full_word[8];
    new_hit.channel             = fch;
    new_hit.hit_time            = {<<{full_word[23:16]}};
    new_hit.time_over_threshold = {tot_hi, tot_lo};
  end

  // Trigger time is built up as the header bytes pass: fine*8, then each
  // coarse byte times 1000 at its byte position.
  assign prod = 18'(b) * COARSE_SCALE;
  always_comb begin
    addend = '0;
    if (off_r == FINE_OFF) begin
      addend = TRIG_W'(b) << FINE_SHIFT;
    end else if (off_r >= COARSE_FIRST && off_r <= COARSE_LAST) begin
      addend = TRIG_W'(prod) << {off_r - COARSE_FIRST, 3'b000};
    end
  end

  assign release_hit = !marker && open_r && (age_r == HOLD_BYTES) && !eof;
  assign open_eff    = marker || open_r;

  always_comb begin
    rb_nxt[0]   = rb_r[1];
    rb_nxt[1]   = rb_r[2];
    rb_nxt[2]   = b;
    rfill_nxt   = (rfill_r == 2'd3) ? rfill_r : rfill_r + 2'd1;
    open_nxt    = open_r;
    off_nxt     = off_r;
    stopped_nxt = stopped_r;
    skip_nxt    = skip_r;
    word_nxt    = word_r;
    wfill_nxt   = wfill_r;
    trig_nxt    = trig_r;
    pend_nxt    = pend_r;
    age_nxt     = age_r;

    if (marker) begin
      open_nxt    = 1'b1;
      off_nxt     = MARK_OFFSET;
      stopped_nxt = 1'b0;
      skip_nxt    = 1'b0;
      wfill_nxt   = 3'd0;
      trig_nxt    = '0;
      age_nxt     = 2'd0;
    end else if (open_r) begin
      if (age_r != 2'd0) begin
        age_nxt = (age_r == HOLD_BYTES) ? 2'd0 : age_r + 2'd1;
      end
      trig_nxt = trig_r + addend;
      if (off_r >= DECODE_START && !stopped_r) begin
        if (wfill_r == 3'd0) begin
          word_nxt  = {24'd0, b};
          wfill_nxt = 3'd1;
        end else if (wfill_r == 3'd1 && word_r[7:0] == IDLE_BYTE
                     && (skip_r || b == IDLE_BYTE)) begin
          // Paired idle: drop the first byte and look again from this one.
          skip_nxt = 1'b1;
          word_nxt = {24'd0, b};
        end else if (wfill_r == 3'd1 && word_r[7:0] == MARK_BYTE && b == MARK_BYTE) begin
          stopped_nxt = 1'b1;
          wfill_nxt   = 3'd0;
        end else if (wfill_r == 3'd4) begin
          wfill_nxt = 3'd0;
          if (hit_ok) begin
            pend_nxt = new_hit;
            age_nxt  = 2'd1;
          end
        end else begin
          word_nxt[{wfill_r[1:0], 3'b000} +: 8] = b;
          wfill_nxt = wfill_r + 3'd1;
        end
      end
      if (off_r < OFFSET_CAP) begin
        off_nxt = off_r + 5'd1;
      end
    end

    if (eof) begin
      rb_nxt[0]   = '0;
      rb_nxt[1]   = '0;
      rb_nxt[2]   = '0;
      rfill_nxt   = 2'd0;
      open_nxt    = 1'b0;
      off_nxt     = 5'd0;
      stopped_nxt = 1'b0;
      skip_nxt    = 1'b0;
      wfill_nxt   = 3'd0;
      trig_nxt    = '0;
      age_nxt     = 2'd0;
    end
  end

  always_comb begin
    no_hit    = '0;
    close_rec = make_record(KIND_CLOSE, no_hit, (off_r >= TRIG_MIN_OFF) ? trig_r : '0);
    drop_rec  = make_record(KIND_DROP, no_hit, '0);
    hit_rec   = make_record(KIND_HIT, pend_r, '0);

    push.count = 2'd0;
    push.rec0  = drop_rec;
    push.rec1  = drop_rec;
    if (marker && open_r) begin
      push.rec0 = close_rec;
      push.count = eof ? 2'd2 : 2'd1;
    end else if (release_hit) begin
      push.rec0  = hit_rec;
      push.count = 2'd1;
    end else if (eof && open_eff) begin
      push.count = 2'd1;
    end
    if (push.count == 2'd1) begin
      push.rec0.last = 1'b1;
    end
    push.rec1.last = 1'b1;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r[0]   <= '0;
      rb_r[1]   <= '0;
      rb_r[2]   <= '0;
      rfill_r   <= 2'd0;
      open_r    <= 1'b0;
      off_r     <= 5'd0;
      stopped_r <= 1'b0;
      skip_r    <= 1'b0;
      wfill_r   <= 3'd0;
      trig_r    <= '0;
      age_r     <= 2'd0;
    end else if (accept) begin
      rb_r      <= rb_nxt;
      rfill_r   <= rfill_nxt;
      open_r    <= open_nxt;
      off_r     <= off_nxt;
      stopped_r <= stopped_nxt;
      skip_r    <= skip_nxt;
      wfill_r   <= wfill_nxt;
      trig_r    <= trig_nxt;
      age_r     <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

>>> sv/phsd_fifo.sv
// Result queue: takes up to two records per cycle, hands out one per cycle while out_ready is high.
module phsd_fifo #(
  parameter int DEPTH = phsd_pkg::REC_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  phsd_pkg::push_t     push,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output phsd_pkg::out_item_t out_data
);
  import phsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_1  = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.count == 2'd1) begin
      wr_ptr_nxt = wr_ptr_1;
    end else if (push.count == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.rec1;
    end
  end

endmodule

>>> sv/pixel_hit_stream_deframer_top.sv
// Top level of the pixel hit stream deframer.
//
//   channel   direction  payload               handshake
//   in_       input      phsd_pkg::in_item_t   in_valid / in_ready
//   out_      output     phsd_pkg::out_item_t  out_valid / out_ready
//   cfg_      input      max_channel, 6 bits   cfg_valid / cfg_ready
//
// One byte is taken every cycle while in_ready is high; its records reach the
// output queue at the same edge and can be taken from the next cycle on. A
// byte gives at most two records, so in_ready drops only while the queue has
// fewer than two free slots. The trigger time is summed one header byte at a
// time, so no stage holds more than one wide add. Synchronous reset returns to
// no open event and max_channel 34; cfg_ready is always high.
module pixel_hit_stream_deframer_top #(
  parameter int FIFO_DEPTH = phsd_pkg::REC_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  phsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output phsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  import phsd_pkg::*;

  logic [5:0] max_channel_r;
  logic       in_accept;
  logic       room2;
  push_t      push;

  assign cfg_ready = 1'b1;
  assign in_ready  = room2;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_channel_r <= MAX_CHANNEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_channel_r <= cfg_data;
    end
  end

  phsd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .in_item     (in_data),
    .max_channel (max_channel_r),
    .push        (push)
  );

  phsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
